// File: sv/strided_multichannel_convolution_top_assert.svh
// Assertion macros used by the convolution block checker.
`ifndef STRIDED_MULTICHANNEL_CONVOLUTION_TOP_ASSERT_SVH
`define STRIDED_MULTICHANNEL_CONVOLUTION_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define SMC_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/smc_pkg.sv
// Package with types, constants and the microcode table of the convolution block.
package smc_pkg;

  localparam int DEF_IMAGE_HEIGHT  = 7;
  localparam int DEF_IMAGE_WIDTH   = 7;
  localparam int DEF_CHANNELS      = 3;
  localparam int DEF_KERNEL_HEIGHT = 3;
  localparam int DEF_KERNEL_WIDTH  = 3;

  localparam logic [1:0] OP_LDW = 2'd0;
  localparam logic [1:0] OP_LDS = 2'd1;
  localparam logic [1:0] OP_REQ = 2'd2;

  localparam logic REG_BIAS   = 1'b0;
  localparam logic REG_STRIDE = 1'b1;

  localparam logic signed [31:0] BIAS_RST   = 32'sd0;
  localparam logic [2:0]         STRIDE_RST = 3'd2;

  localparam int UPC_W = 3;

  localparam logic [UPC_W-1:0] U_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] U_CHECK  = 3'd1;
  localparam logic [UPC_W-1:0] U_LOOP   = 3'd2;
  localparam logic [UPC_W-1:0] U_DRAIN1 = 3'd3;
  localparam logic [UPC_W-1:0] U_DRAIN2 = 3'd4;
  localparam logic [UPC_W-1:0] U_OUT    = 3'd5;
  localparam logic [UPC_W-1:0] U_WAIT   = 3'd6;
  localparam logic [UPC_W-1:0] U_SPARE  = 3'd7;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_OOR,
    C_MORE,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [1:0]         channel;
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [39:0] conv_sum;
    logic               in_range;
  } out_item_t;

  typedef struct packed {
    logic             in_ready;
    logic             init;
    logic             issue;
    logic             out_ld;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic req_acc;
    logic oor;
    logic more;
    logic out_free;
  } stat_t;

  function automatic ctrl_t ucode_rom(input logic [UPC_W-1:0] pc);
    ctrl_t cw;
    cw = '{in_ready: 1'b0, init: 1'b0, issue: 1'b0, out_ld: 1'b0,
           cond: C_NEVER, target: U_IDLE};
    unique case (pc)
      U_IDLE: begin
        cw.in_ready = 1'b1;
        cw.cond     = C_NO_REQ;
        cw.target   = U_IDLE;
      end
      U_CHECK: begin
        cw.init   = 1'b1;
        cw.cond   = C_OOR;
        cw.target = U_OUT;
      end
      U_LOOP: begin
        cw.issue  = 1'b1;
        cw.cond   = C_MORE;
        cw.target = U_LOOP;
      end
      U_DRAIN1: cw.cond = C_NEVER;
      U_DRAIN2: cw.cond = C_NEVER;
      U_OUT: begin
        cw.out_ld = 1'b1;
        cw.cond   = C_OUT_FREE;
        cw.target = U_IDLE;
      end
      U_WAIT: begin
        cw.cond   = C_ALWAYS;
        cw.target = U_OUT;
      end
      U_SPARE: begin
        cw.cond   = C_ALWAYS;
        cw.target = U_IDLE;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = U_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: sv/smc_cfg.sv
// Configuration registers of the convolution block behind an APB-style port.
module smc_cfg
  import smc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic signed [31:0] bias,
  output logic [2:0]         stride
);

  logic signed [31:0] bias_r;
  logic [2:0]         stride_r;
  logic               wr_en;
  logic               reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r   <= BIAS_RST;
      stride_r <= STRIDE_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_BIAS:   bias_r   <= pwdata;
        REG_STRIDE: stride_r <= pwdata[2:0];
        default:    bias_r   <= bias_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BIAS:   prdata = bias_r;
      REG_STRIDE: prdata = {29'd0, stride_r};
      default:    prdata = 32'd0;
    endcase
  end

  assign bias   = bias_r;
  assign stride = stride_r;

endmodule

// File: sv/smc_seq.sv
// Microcode sequencer: step counter, control table lookup and conditional jumps.
module smc_seq
  import smc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  logic [UPC_W-1:0] pc_r;
  logic [UPC_W-1:0] pc_nxt;
  logic             take;

  assign ctrl = ucode_rom(pc_r);

  always_comb begin
    case (ctrl.cond)
      C_NEVER:    take = 1'b0;
      C_ALWAYS:   take = 1'b1;
      C_NO_REQ:   take = !stat.req_acc;
      C_OOR:      take = stat.oor;
      C_MORE:     take = stat.more;
      C_OUT_FREE: take = stat.out_free;
      default:    take = 1'b1;
    endcase
    pc_nxt = take ? ctrl.target : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= U_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// File: sv/smc_dp.sv
// Datapath: weight and sample memories, window counters, multiply-accumulate, output register.
module smc_dp
  import smc_pkg::*;
#(
  parameter int IMAGE_HEIGHT  = DEF_IMAGE_HEIGHT,
  parameter int IMAGE_WIDTH   = DEF_IMAGE_WIDTH,
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int KERNEL_HEIGHT = DEF_KERNEL_HEIGHT,
  parameter int KERNEL_WIDTH  = DEF_KERNEL_WIDTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ctrl_t              ctrl,
  output stat_t              stat,
  input  logic signed [31:0] bias,
  input  logic [2:0]         stride,
  input  logic               in_valid,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  localparam int WDEPTH = CHANNELS * KERNEL_HEIGHT * KERNEL_WIDTH;
  localparam int SDEPTH = CHANNELS * IMAGE_HEIGHT * IMAGE_WIDTH;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int SA_W   = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int K_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int I_W    = (KERNEL_HEIGHT > 1) ? $clog2(KERNEL_HEIGHT) : 1;
  localparam int J_W    = (KERNEL_WIDTH > 1) ? $clog2(KERNEL_WIDTH) : 1;

  logic signed [15:0] wmem [WDEPTH];
  logic signed [15:0] smem [SDEPTH];

  logic               accept;
  logic [2:0]         step;
  logic [WA_W-1:0]    wa_ld;
  logic [SA_W-1:0]    sa_ld;
  logic [SA_W-1:0]    sa_rd;
  logic               w_we;
  logic               s_we;
  logic               oor;
  logic               last;
  logic               out_free;

  logic [5:0]         r0_r;
  logic [5:0]         c0_r;
  logic [K_W-1:0]     k_r;
  logic [I_W-1:0]     i_r;
  logic [J_W-1:0]     j_r;
  logic [WA_W-1:0]    widx_r;
  logic               rd_v_r;
  logic               prod_v_r;
  logic signed [15:0] w_rd_r;
  logic signed [15:0] s_rd_r;
  logic signed [31:0] prod_r;
  logic signed [39:0] acc_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  assign accept = in_valid && ctrl.in_ready;
  assign step   = (stride == 3'd0) ? 3'd1 : stride;

  assign wa_ld = WA_W'((32'(in_data.channel) * KERNEL_HEIGHT + 32'(in_data.row))
                       * KERNEL_WIDTH + 32'(in_data.col));
  assign sa_ld = SA_W'((32'(in_data.channel) * IMAGE_HEIGHT + 32'(in_data.row))
                       * IMAGE_WIDTH + 32'(in_data.col));
  assign sa_rd = SA_W'((32'(k_r) * IMAGE_HEIGHT + 32'(r0_r) + 32'(i_r)) * IMAGE_WIDTH
                       + 32'(c0_r) + 32'(j_r));

  assign w_we = accept && (in_data.op == OP_LDW) && (32'(in_data.channel) < CHANNELS)
                && (32'(in_data.row) < KERNEL_HEIGHT) && (32'(in_data.col) < KERNEL_WIDTH);
  assign s_we = accept && (in_data.op == OP_LDS) && (32'(in_data.channel) < CHANNELS)
                && (32'(in_data.row) < IMAGE_HEIGHT) && (32'(in_data.col) < IMAGE_WIDTH);

  assign oor = ((8'(r0_r) + 8'(KERNEL_HEIGHT)) > 8'(IMAGE_HEIGHT))
               || ((8'(c0_r) + 8'(KERNEL_WIDTH)) > 8'(IMAGE_WIDTH));

  assign last = (k_r == K_W'(CHANNELS - 1)) && (i_r == I_W'(KERNEL_HEIGHT - 1))
                && (j_r == J_W'(KERNEL_WIDTH - 1));

  assign out_free = !out_valid_r || out_ready;

  assign stat.req_acc  = accept && (in_data.op == OP_REQ);
  assign stat.oor      = oor;
  assign stat.more     = !last;
  assign stat.out_free = out_free;

  always_ff @(posedge clk) begin
    if (w_we) begin
      wmem[wa_ld] <= in_data.value;
    end
    if (ctrl.issue) begin
      w_rd_r <= wmem[widx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[sa_ld] <= in_data.value;
    end
    if (ctrl.issue) begin
      s_rd_r <= smem[sa_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (stat.req_acc) begin
      r0_r <= 6'(in_data.row) * 6'(step);
      c0_r <= 6'(in_data.col) * 6'(step);
    end
    if (ctrl.init) begin
      k_r    <= '0;
      i_r    <= '0;
      j_r    <= '0;
      widx_r <= '0;
    end else if (ctrl.issue) begin
      widx_r <= widx_r + 1'b1;
      if (j_r == J_W'(KERNEL_WIDTH - 1)) begin
        j_r <= '0;
        if (i_r == I_W'(KERNEL_HEIGHT - 1)) begin
          i_r <= '0;
          k_r <= k_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
        end
      end else begin
        j_r <= j_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      rd_v_r   <= ctrl.issue;
      prod_v_r <= rd_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_v_r) begin
      prod_r <= s_rd_r * w_rd_r;
    end
    if (ctrl.init) begin
      acc_r <= 40'(bias);
    end else if (prod_v_r) begin
      acc_r <= acc_r + 40'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_ld && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_ld && out_free) begin
      out_data_r.conv_sum <= oor ? 40'sd0 : acc_r;
      out_data_r.in_range <= !oor;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/strided_multichannel_convolution_top.sv
// Top level of the strided multi-channel 2D convolution block.
// Items enter on in_valid/in_ready with an in_item_t payload. Op 0 writes one
// filter weight and op 1 writes one input sample at channel, row and column;
// a load gives no result and the block stays ready for the next item. Op 2
// requests the output at an output row and column and gives one out_item_t on
// out_valid/out_ready. The block takes no new item while a request runs and
// is ready again when its result is loaded into the output register; a
// window outside the input skips the loop and answers with in_range low and a
// zero sum. The request time is set by the single multiply-accumulate unit and
// the one read port of each store, driven by a microcode loop that issues one
// window element per cycle.
// The bias and stride registers sit behind the APB-style port; the user must
// write them only while the block is idle (the block does not enforce). Reset
// clears the sequencer, the output valid and the registers (bias 0,
// stride 2); the stores hold nothing valid until written. When the receiver
// stalls, the result waits in the output register and loads are still accepted;
// a following request finishes its sum and waits until that register is free.
module strided_multichannel_convolution_top
  import smc_pkg::*;
#(
  parameter int IMAGE_HEIGHT  = DEF_IMAGE_HEIGHT,
  parameter int IMAGE_WIDTH   = DEF_IMAGE_WIDTH,
  parameter int CHANNELS      = DEF_CHANNELS,
  parameter int KERNEL_HEIGHT = DEF_KERNEL_HEIGHT,
  parameter int KERNEL_WIDTH  = DEF_KERNEL_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_t              ctrl;
  stat_t              stat;
  logic signed [31:0] bias;
  logic [2:0]         stride;

  assign in_ready = ctrl.in_ready;

  smc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .bias    (bias),
    .stride  (stride)
  );

  smc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  smc_dp #(
    .IMAGE_HEIGHT  (IMAGE_HEIGHT),
    .IMAGE_WIDTH   (IMAGE_WIDTH),
    .CHANNELS      (CHANNELS),
    .KERNEL_HEIGHT (KERNEL_HEIGHT),
    .KERNEL_WIDTH  (KERNEL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .stat      (stat),
    .bias      (bias),
    .stride    (stride),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/smc_checker.sv
// Port-level checker of the convolution block and its bind to the top level.
`include "strided_multichannel_convolution_top_assert.svh"

module smc_checker
  import smc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `SMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled item changed")
  `SMC_ASSERT_NOW(a_oor_zero, out_valid && !out_data.in_range, out_data.conv_sum == 40'sd0, "out-of-range item has nonzero sum")
  `SMC_ASSERT_RST(a_rst_idle, !rst_n, !out_valid, "item shown right after reset")
  `SMC_ASSERT_NEXT(a_req_busy, in_valid && in_ready && in_data.op == OP_REQ, !in_ready, "input accepted while a request is running")

endmodule

bind strided_multichannel_convolution_top smc_checker u_smc_checker (.*);
